// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the I2C master phase sequencer.
// In synthesis builds the macros expand to nothing.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define I2CMS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("I2C sequencer: same-cycle check failed");
// Next-cycle implication, disabled during reset.
`define I2CMS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("I2C sequencer: next-cycle check failed");
`else
`define I2CMS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define I2CMS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== sv/i2cms_pkg.sv =====
// ---------------------------------------------------------------------------
// I2C master phase sequencer package
// Command codes, the queued command descriptor and phase counter limits.
// ---------------------------------------------------------------------------
package i2cms_pkg;

  // Command codes carried by an input transfer.
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // A classified command, as held in the queue between front and back.
  typedef struct packed {
    action_t    action;
    logic [8:0] bits;     // SDA level per bit slot, slot 0 at bit 8, ack slot at bit 0
    logic       nack;     // acknowledge level sampled on a write
    logic [7:0] rx_byte;  // assembled byte on a read
    logic       busy;     // bus busy level shown during the run
  } cmd_desc_t;

  // Queue status seen by the front end.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  // Phase counter limits.
  localparam logic [1:0] START_SUB_LAST = 2'd3;
  localparam logic [1:0] STOP_SUB_LAST  = 2'd2;
  localparam logic [1:0] BYTE_SUB_LAST  = 2'd2;
  localparam logic [1:0] SUB_CLOCK_HIGH = 2'd1;
  localparam logic [3:0] BYTE_SLOT_LAST = 4'd8;

endpackage

// ===== sv/i2cms_if.sv =====
// ---------------------------------------------------------------------------
// I2C master phase sequencer channels
// Command channel and bus phase channel, valid/ready handshaked.
// ---------------------------------------------------------------------------
interface i2cms_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] tx_byte;
  logic       send_ack;
  logic [8:0] slave_sda;

  modport source (output valid, action, tx_byte, send_ack, slave_sda, input ready);
  modport sink   (input valid, action, tx_byte, send_ack, slave_sda, output ready);
endinterface

interface i2cms_phase_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda;
  logic       nack;
  logic [7:0] rx_byte;
  logic       bus_busy;
  logic       last;

  modport source (output valid, scl, sda, nack, rx_byte, bus_busy, last, input ready);
  modport sink   (input valid, scl, sda, nack, rx_byte, bus_busy, last, output ready);
endinterface

// ===== sv/i2cms_front.sv =====
// ---------------------------------------------------------------------------
// I2C command front end
// Accepts commands, tracks the bus busy flag and builds queue descriptors.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cms_front (
  input  logic                  clk,
  input  logic                  rst_n,
  i2cms_cmd_if.sink             in_cmd,
  input  i2cms_pkg::fifo_stat_t stat,
  output logic                  push,
  output i2cms_pkg::cmd_desc_t  push_desc
);

  logic                busy_r;
  logic                busy_nxt;
  i2cms_pkg::action_t  act;

  assign act         = i2cms_pkg::action_t'(in_cmd.action);
  assign in_cmd.ready = !stat.full;
  assign push        = in_cmd.valid && in_cmd.ready;

  // Classify the command and work out the busy flag that follows it.
  always_comb begin
    busy_nxt           = busy_r;
    push_desc.action   = act;
    push_desc.bits     = 9'h1FF;
    push_desc.nack     = 1'b0;
    push_desc.rx_byte  = 8'h00;
    push_desc.busy     = busy_r;
    unique case (act)
      i2cms_pkg::ACT_START: begin
        busy_nxt       = 1'b1;
        push_desc.busy = 1'b1;
      end
      i2cms_pkg::ACT_STOP: begin
        busy_nxt = 1'b0;
      end
      i2cms_pkg::ACT_WRITE: begin
        push_desc.bits = {in_cmd.tx_byte, 1'b1};
        push_desc.nack = in_cmd.slave_sda[0];
      end
      i2cms_pkg::ACT_READ: begin
        push_desc.bits    = {8'hFF, !in_cmd.send_ack};
        push_desc.rx_byte = in_cmd.slave_sda[8:1];
      end
      default: begin
        busy_nxt = busy_r;
      end
    endcase
  end

  // Busy flag, updated as each command enters the queue.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (push) begin
      busy_r <= busy_nxt;
    end
  end

  `I2CMS_ASSERT_NXT(a_start_sets_busy, clk, rst_n, push && (act == i2cms_pkg::ACT_START), busy_r)
  `I2CMS_ASSERT_NXT(a_stop_clears_busy, clk, rst_n, push && (act == i2cms_pkg::ACT_STOP), !busy_r)

endmodule

// ===== sv/i2cms_cmd_fifo.sv =====
// ---------------------------------------------------------------------------
// I2C command queue
// Two-entry queue of descriptors between the front end and phase generator.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cms_cmd_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  i2cms_pkg::cmd_desc_t  push_desc,
  input  logic                  pop,
  output i2cms_pkg::cmd_desc_t  head_desc,
  output i2cms_pkg::fifo_stat_t stat
);

  i2cms_pkg::cmd_desc_t                 mem_r [i2cms_pkg::FIFO_DEPTH];
  logic [i2cms_pkg::FIFO_PTR_W-1:0]     wr_ptr_r;
  logic [i2cms_pkg::FIFO_PTR_W-1:0]     rd_ptr_r;
  logic [i2cms_pkg::FIFO_CNT_W-1:0]     count_r;

  assign stat.full  = (count_r == i2cms_pkg::FIFO_CNT_W'(i2cms_pkg::FIFO_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_desc  = mem_r[rd_ptr_r];

  // Storage: written on push, no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `I2CMS_ASSERT_IMP(a_no_pop_empty, clk, rst_n, stat.empty, !pop)
  `I2CMS_ASSERT_IMP(a_no_push_full, clk, rst_n, stat.full, !push)

endmodule

// ===== sv/i2cms_phase_gen.sv =====
// ---------------------------------------------------------------------------
// I2C bus phase generator
// Walks the queued command into the output register, one bus phase per cycle unless stalled.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cms_phase_gen (
  input  logic                  clk,
  input  logic                  rst_n,
  input  i2cms_pkg::cmd_desc_t  head_desc,
  input  i2cms_pkg::fifo_stat_t stat,
  output logic                  pop,
  i2cms_phase_if.source         out_phase
);

  logic [1:0] sub_r;
  logic [1:0] sub_nxt;
  logic [3:0] slot_r;
  logic [3:0] slot_nxt;
  logic       out_valid_r;
  logic       scl_r;
  logic       sda_r;
  logic       nack_r;
  logic [7:0] rx_byte_r;
  logic       busy_r;
  logic       last_r;

  logic       head_valid;
  logic       advance;
  logic       load;
  logic       ph_scl;
  logic       ph_sda;
  logic       ph_busy;
  logic       ph_last;
  logic       slot_bit;

  assign head_valid = !stat.empty;
  assign advance    = !out_valid_r || out_phase.ready;
  assign load       = advance && head_valid;
  assign pop        = load && ph_last;
  assign slot_bit   = head_desc.bits[i2cms_pkg::BYTE_SLOT_LAST - slot_r];

  // Phase decode for the command at the queue head.
  always_comb begin
    ph_scl   = 1'b0;
    ph_sda   = 1'b1;
    ph_busy  = head_desc.busy;
    ph_last  = 1'b0;
    unique case (head_desc.action)
      i2cms_pkg::ACT_START: begin
        ph_scl  = sub_r[0] ^ sub_r[1];
        ph_sda  = !sub_r[1];
        ph_last = (sub_r == i2cms_pkg::START_SUB_LAST);
      end
      i2cms_pkg::ACT_STOP: begin
        ph_scl  = (sub_r != 2'd0);
        ph_last = (sub_r == i2cms_pkg::STOP_SUB_LAST);
        ph_sda  = ph_last;
        ph_busy = head_desc.busy && !ph_last;
      end
      i2cms_pkg::ACT_WRITE, i2cms_pkg::ACT_READ: begin
        ph_scl  = (sub_r == i2cms_pkg::SUB_CLOCK_HIGH);
        ph_sda  = slot_bit;
        ph_last = (slot_r == i2cms_pkg::BYTE_SLOT_LAST) &&
                  (sub_r == i2cms_pkg::BYTE_SUB_LAST);
      end
      default: begin
        ph_last = 1'b0;
      end
    endcase
  end

  // Next position within the run.
  always_comb begin
    sub_nxt  = sub_r + 1'b1;
    slot_nxt = slot_r;
    if (ph_last) begin
      sub_nxt  = '0;
      slot_nxt = '0;
    end else if (sub_r == i2cms_pkg::BYTE_SUB_LAST &&
                 (head_desc.action == i2cms_pkg::ACT_WRITE ||
                  head_desc.action == i2cms_pkg::ACT_READ)) begin
      sub_nxt  = '0;
      slot_nxt = slot_r + 1'b1;
    end
  end

  // Control state: phase counters and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r       <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        sub_r  <= sub_nxt;
        slot_r <= slot_nxt;
      end
      if (advance) begin
        out_valid_r <= head_valid;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      scl_r     <= ph_scl;
      sda_r     <= ph_sda;
      nack_r    <= ph_last && head_desc.nack;
      rx_byte_r <= ph_last ? head_desc.rx_byte : 8'h00;
      busy_r    <= ph_busy;
      last_r    <= ph_last;
    end
  end

  assign out_phase.valid    = out_valid_r;
  assign out_phase.scl      = scl_r;
  assign out_phase.sda      = sda_r;
  assign out_phase.nack     = nack_r;
  assign out_phase.rx_byte  = rx_byte_r;
  assign out_phase.bus_busy = busy_r;
  assign out_phase.last     = last_r;

  `I2CMS_ASSERT_IMP(a_slot_range, clk, rst_n, 1'b1, slot_r <= i2cms_pkg::BYTE_SLOT_LAST)
  `I2CMS_ASSERT_NXT(a_pop_shows_last, clk, rst_n, pop, out_phase.valid && out_phase.last)

endmodule

// ===== sv/i2c_master_bit_sequencer.sv =====
// The first bus phase of an accepted command passes through the command queue and
// then the output register. Throughput: one bus phase per cycle while out_phase.ready
// allows, set by the phase generator, which emits a single phase per clock.
// A two-entry command queue lets new commands be accepted while a run is in progress.
// Reset (synchronous, rst_n low) empties the queue and output register and clears
// the bus busy flag.
// ---------------------------------------------------------------------------
// I2C master phase sequencer
// Turns start, stop, write and read commands into runs of SCL/SDA bus phases.
// ---------------------------------------------------------------------------
module i2c_master_bit_sequencer (
  input  logic          clk,
  input  logic          rst_n,
  i2cms_cmd_if.sink     in_cmd,
  i2cms_phase_if.source out_phase
);

  logic                  push;
  logic                  pop;
  i2cms_pkg::cmd_desc_t  push_desc;
  i2cms_pkg::cmd_desc_t  head_desc;
  i2cms_pkg::fifo_stat_t stat;

  // Front end: accepts and classifies commands.
  i2cms_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (in_cmd),
    .stat      (stat),
    .push      (push),
    .push_desc (push_desc)
  );

  // Queue between front end and phase generator.
  i2cms_cmd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .stat      (stat)
  );

  // Back end: emits the bus phases.
  i2cms_phase_gen u_phase_gen (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_desc (head_desc),
    .stat      (stat),
    .pop       (pop),
    .out_phase (out_phase)
  );

endmodule

// ===== bench/testbench.sv =====
// ---------------------------------------------------------------------------
// I2C master phase sequencer testbench
// Sends start, stop, write and read commands over the command channel, with
// random gaps on both channels, and compares every bus phase that comes back
// with the phase run predicted for the accepted command.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One command as offered on the input channel.
  typedef struct {
    i2cms_pkg::action_t action;
    logic [7:0]         tx_byte;
    logic               send_ack;
    logic [8:0]         slave_sda;
  } i2c_cmd_t;

  // One bus phase as seen on the output channel.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       nack;
    logic [7:0] rx_byte;
    logic       bus_busy;
    logic       last;
  } bus_phase_t;

  localparam int unsigned RANDOM_ITEMS  = 140;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned TAIL_CYCLES   = 30;
  localparam int unsigned REPORT_LIMIT  = 10;

  // Predicts the phase runs and holds the phases still owed by the block.
  class phase_scoreboard;
    bus_phase_t  owed_q[$];
    logic        bus_held;
    int unsigned mismatches;

    function new();
      bus_held   = 1'b0;
      mismatches = 0;
    endfunction

    function void push_phase(logic scl, logic sda, logic nack, logic [7:0] rx,
                             logic busy, logic last);
      bus_phase_t p;
      p.scl      = scl;
      p.sda      = sda;
      p.nack     = nack;
      p.rx_byte  = rx;
      p.bus_busy = busy;
      p.last     = last;
      owed_q.push_back(p);
    endfunction

    // Works out the phase run of an accepted command.
    function void note_command(i2c_cmd_t c);
      logic       busy_now;
      logic [7:0] bit_mask;
      logic       b;
      logic       ack_level;
      busy_now = bus_held;
      bit_mask = 8'h80;
      case (c.action)
        i2cms_pkg::ACT_START: begin
          // SDA is released while SCL is low, so a repeated start is legal.
          bus_held = 1'b1;
          push_phase(1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0);
          push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0);
          push_phase(1'b1, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0);
          push_phase(1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b1);
        end
        i2cms_pkg::ACT_STOP: begin
          // Busy shows the prior flag until the final phase.
          bus_held = 1'b0;
          push_phase(1'b0, 1'b0, 1'b0, 8'h00, busy_now, 1'b0);
          push_phase(1'b1, 1'b0, 1'b0, 8'h00, busy_now, 1'b0);
          push_phase(1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1);
        end
        i2cms_pkg::ACT_WRITE: begin
          for (int i = 0; i < 8; i++) begin
            b = |(c.tx_byte & bit_mask);
            push_phase(1'b0, b, 1'b0, 8'h00, busy_now, 1'b0);
            push_phase(1'b1, b, 1'b0, 8'h00, busy_now, 1'b0);
            push_phase(1'b0, b, 1'b0, 8'h00, busy_now, 1'b0);
            bit_mask = bit_mask >> 1;
          end
          push_phase(1'b0, 1'b1, 1'b0, 8'h00, busy_now, 1'b0);
          push_phase(1'b1, 1'b1, 1'b0, 8'h00, busy_now, 1'b0);
          push_phase(1'b0, 1'b1, c.slave_sda[0], 8'h00, busy_now, 1'b1);
        end
        default: begin
          // Read: SDA released for the data bits, then ACK or NACK driven.
          ack_level = ~c.send_ack;
          for (int i = 0; i < 8; i++) begin
            push_phase(1'b0, 1'b1, 1'b0, 8'h00, busy_now, 1'b0);
            push_phase(1'b1, 1'b1, 1'b0, 8'h00, busy_now, 1'b0);
            push_phase(1'b0, 1'b1, 1'b0, 8'h00, busy_now, 1'b0);
          end
          push_phase(1'b0, ack_level, 1'b0, 8'h00, busy_now, 1'b0);
          push_phase(1'b1, ack_level, 1'b0, 8'h00, busy_now, 1'b0);
          push_phase(1'b0, ack_level, 1'b0, c.slave_sda[8:1], busy_now, 1'b1);
        end
      endcase
    endfunction

    // Compares one received phase with the oldest one owed.
    function void check_phase(bus_phase_t got);
      bus_phase_t want;
      if (owed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected bus phase: scl=%0b sda=%0b nack=%0b rx=%02h busy=%0b last=%0b",
                   got.scl, got.sda, got.nack, got.rx_byte, got.bus_busy, got.last);
        return;
      end
      want = owed_q.pop_front();
      if (got.scl !== want.scl || got.sda !== want.sda || got.nack !== want.nack ||
          got.rx_byte !== want.rx_byte || got.bus_busy !== want.bus_busy ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("bus phase mismatch: expected scl=%0b sda=%0b nack=%0b rx=%02h ",
                   want.scl, want.sda, want.nack, want.rx_byte,
                   "busy=%0b last=%0b, ", want.bus_busy, want.last,
                   "got scl=%0b sda=%0b nack=%0b rx=%02h ",
                   got.scl, got.sda, got.nack, got.rx_byte,
                   "busy=%0b last=%0b", got.bus_busy, got.last);
      end
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  i2cms_cmd_if   cmd_ch ();
  i2cms_phase_if phase_ch ();

  i2c_master_bit_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_cmd    (cmd_ch),
    .out_phase (phase_ch)
  );

  phase_scoreboard sb = new();

  int unsigned sent_count;
  int unsigned cycle_count;
  int unsigned phases_seen;
  bit          tx_burst;
  bit          rx_burst;
  bit          long_hold_req;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic i2c_cmd_t build_cmd(i2cms_pkg::action_t a, logic [7:0] tx, logic ack,
                                         logic [8:0] slave);
    i2c_cmd_t c;
    c.action    = a;
    c.tx_byte   = tx;
    c.send_ack  = ack;
    c.slave_sda = slave;
    return c;
  endfunction

  function automatic int unsigned next_gap();
    return tx_burst ? 0 : $urandom_range(0, 8);
  endfunction

  // Offers one command after an idle gap and waits for its transfer.
  task automatic offer_command(i2c_cmd_t c);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.action    <= c.action;
    cmd_ch.tx_byte   <= c.tx_byte;
    cmd_ch.send_ack  <= c.send_ack;
    cmd_ch.slave_sda <= c.slave_sda;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    sb.note_command(c);
    sent_count++;
  endtask

  task automatic wait_for_drain();
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // Random byte with the acknowledge slot mostly driven low by the slave.
  function automatic logic [8:0] slave_acking();
    return {8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0)};
  endfunction

  // One well-formed bus transaction with random content.
  task automatic run_transaction();
    int unsigned n_bytes;
    bit          reading;
    reading = 1'($urandom_range(0, 1));
    offer_command(build_cmd(i2cms_pkg::ACT_START, 8'h00, 1'($urandom_range(0, 1)),
                            9'($urandom_range(0, 511))));
    offer_command(build_cmd(i2cms_pkg::ACT_WRITE, {7'($urandom_range(0, 127)), reading},
                            1'($urandom_range(0, 1)), slave_acking()));
    // Register address then a repeated start for some reads.
    if (reading && $urandom_range(0, 1)) begin
      offer_command(build_cmd(i2cms_pkg::ACT_WRITE, 8'($urandom_range(0, 255)),
                              1'($urandom_range(0, 1)), slave_acking()));
      offer_command(build_cmd(i2cms_pkg::ACT_START, 8'($urandom_range(0, 255)),
                              1'b0, 9'h000));
      offer_command(build_cmd(i2cms_pkg::ACT_WRITE, {7'($urandom_range(0, 127)), 1'b1},
                              1'b0, slave_acking()));
    end
    n_bytes = $urandom_range(1, 4);
    for (int i = 0; i < n_bytes; i++) begin
      if (reading)
        offer_command(build_cmd(i2cms_pkg::ACT_READ, 8'($urandom_range(0, 255)),
                                1'(i != n_bytes - 1), 9'($urandom_range(0, 511))));
      else
        offer_command(build_cmd(i2cms_pkg::ACT_WRITE, 8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), slave_acking()));
    end
    offer_command(build_cmd(i2cms_pkg::ACT_STOP, 8'($urandom_range(0, 255)),
                            1'($urandom_range(0, 1)), 9'($urandom_range(0, 511))));
  endtask

  // Phase receiver: random stalls, plus one long hold-off on request.
  initial begin : phase_receiver
    int unsigned stall;
    bus_phase_t  got;
    phase_ch.ready <= 1'b0;
    phases_seen = 0;
    rx_burst    = 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = LONG_HOLD;
      end else if (rx_burst) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 8);
      end
      if (stall != 0) begin
        phase_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      phase_ch.ready <= 1'b1;
      do @(posedge clk); while (phase_ch.valid !== 1'b1);
      got.scl      = phase_ch.scl;
      got.sda      = phase_ch.sda;
      got.nack     = phase_ch.nack;
      got.rx_byte  = phase_ch.rx_byte;
      got.bus_busy = phase_ch.bus_busy;
      got.last     = phase_ch.last;
      sb.check_phase(got);
      phases_seen++;
      if (phases_seen % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // Reset, stimulus and the final verdict.
  initial begin : command_sender
    bit held_off;
    bit drained;
    held_off = 1'b0;
    drained  = 1'b0;
    sent_count    = 0;
    tx_burst      = 1'b0;
    long_hold_req = 1'b0;
    rst_n            <= 1'b0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.action    <= i2cms_pkg::ACT_START;
    cmd_ch.tx_byte   <= 8'h00;
    cmd_ch.send_ack  <= 1'b0;
    cmd_ch.slave_sda <= 9'h000;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: commands on an idle bus, extremes of every field,
    // a repeated start and a stop on an idle bus.
    offer_command(build_cmd(i2cms_pkg::ACT_STOP,  8'h00, 1'b0, 9'h000));
    offer_command(build_cmd(i2cms_pkg::ACT_WRITE, 8'hFF, 1'b1, 9'h1FF));
    offer_command(build_cmd(i2cms_pkg::ACT_READ,  8'h00, 1'b1, 9'h1FF));
    offer_command(build_cmd(i2cms_pkg::ACT_START, 8'hFF, 1'b1, 9'h1FF));
    offer_command(build_cmd(i2cms_pkg::ACT_WRITE, 8'h00, 1'b0, 9'h000));
    offer_command(build_cmd(i2cms_pkg::ACT_WRITE, 8'hFF, 1'b0, 9'h001));
    offer_command(build_cmd(i2cms_pkg::ACT_WRITE, 8'hA5, 1'b1, 9'h1FE));
    offer_command(build_cmd(i2cms_pkg::ACT_WRITE, 8'h5A, 1'b0, 9'h0AB));
    offer_command(build_cmd(i2cms_pkg::ACT_READ,  8'hFF, 1'b1, 9'h1FF));
    offer_command(build_cmd(i2cms_pkg::ACT_READ,  8'h00, 1'b0, 9'h000));
    offer_command(build_cmd(i2cms_pkg::ACT_READ,  8'h3C, 1'b1, 9'h155));
    offer_command(build_cmd(i2cms_pkg::ACT_START, 8'h00, 1'b0, 9'h000));
    offer_command(build_cmd(i2cms_pkg::ACT_READ,  8'hC3, 1'b0, 9'h0AA));
    offer_command(build_cmd(i2cms_pkg::ACT_STOP,  8'hFF, 1'b1, 9'h1FF));
    offer_command(build_cmd(i2cms_pkg::ACT_STOP,  8'h00, 1'b0, 9'h000));
    offer_command(build_cmd(i2cms_pkg::ACT_READ,  8'h00, 1'b0, 9'h101));
    offer_command(build_cmd(i2cms_pkg::ACT_START, 8'h00, 1'b0, 9'h000));
    offer_command(build_cmd(i2cms_pkg::ACT_START, 8'h00, 1'b0, 9'h000));
    offer_command(build_cmd(i2cms_pkg::ACT_STOP,  8'h00, 1'b0, 9'h000));

    // Random: mostly well-formed transactions, some stray commands.
    while (sent_count < 19 + RANDOM_ITEMS) begin
      tx_burst = ($urandom_range(0, 3) == 0);
      if (!held_off && sent_count >= 60) begin
        // The receiver stalls for a long stretch while commands keep coming.
        held_off      = 1'b1;
        tx_burst      = 1'b1;
        long_hold_req = 1'b1;
      end
      if (!drained && sent_count >= 110) begin
        drained = 1'b1;
        cmd_ch.valid <= 1'b0;
        wait_for_drain();
      end
      if ($urandom_range(0, 9) == 0)
        offer_command(build_cmd(i2cms_pkg::action_t'($urandom_range(0, 3)),
                                8'($urandom_range(0, 255)),
                                1'($urandom_range(0, 1)), 9'($urandom_range(0, 511))));
      else
        run_transaction();
    end
    cmd_ch.valid <= 1'b0;

    // Let the last runs come out, then allow for any stray phase.
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
